### sv/dsff_pkg.sv
// Shared types, constants and helper functions for the dual sensor force fusion block.
package dsff_pkg;

   localparam int FORCE_WIDTH = 24;
   localparam int AGE_WIDTH   = 17;

   localparam int Q16_W    = 17;
   localparam int STALE_W  = 16;
   localparam int PREF_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int DEN_W   = Q16_W + 1;
   localparam int PROD_W  = DEN_W + FORCE_WIDTH;
   localparam int ACC_W   = FORCE_WIDTH + DEN_W + 1;
   localparam int CNT_W   = $clog2(FORCE_WIDTH);
   localparam int AGE_CMP_W = (AGE_WIDTH > STALE_W + 1) ? AGE_WIDTH : STALE_W + 1;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FORCE_WIDTH - 1);

   localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(65536);
   localparam logic [Q16_W-1:0] DEF_PW  = Q16_W'(45875);
   localparam logic [Q16_W-1:0] DEF_WW  = Q16_W'(19661);
   localparam logic [Q16_W-1:0] CONF_P  = Q16_W'(45875);
   localparam logic [Q16_W-1:0] CONF_W  = Q16_W'(36045);
   localparam logic [Q16_W-1:0] CONF_F  = Q16_W'(65536);

   localparam logic signed [FORCE_WIDTH-1:0] AZ_HI = FORCE_WIDTH'(64);
   localparam logic signed [FORCE_WIDTH-1:0] AZ_LO = -FORCE_WIDTH'(64);

   typedef enum logic [1:0] {
      SRC_INVALID  = 2'd0,
      SRC_PRESSURE = 2'd1,
      SRC_WRENCH   = 2'd2,
      SRC_FUSED    = 2'd3
   } src_type;

   typedef enum logic [PREF_W-1:0] {
      PREF_FUSED    = 2'd0,
      PREF_PRESSURE = 2'd1,
      PREF_WRENCH   = 2'd2,
      PREF_ALT      = 2'd3
   } pref_type;

   typedef enum logic {
      OP_ESTIMATE = 1'b0,
      OP_CLEAR    = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESSURE_WEIGHT = 3'd0,
      CSR_WRENCH_WEIGHT   = 3'd1,
      CSR_STALE_TIMEOUT   = 3'd2,
      CSR_HARD_TIMEOUT    = 3'd3,
      CSR_MIN_CONFIDENCE  = 3'd4,
      CSR_AUTO_ZERO       = 3'd5,
      CSR_PREFERRED       = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_P,
      BK_MUL_W,
      BK_PREP,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [Q16_W-1:0]   weight_p;
      logic [Q16_W-1:0]   weight_w;
      logic [STALE_W-1:0] stale_timeout;
      logic [Q16_W-1:0]   conf_floor;
      logic               auto_zero_enable;
      pref_type           src_pref;
   } cfg_type;

   typedef struct packed {
      src_type                src;
      logic [Q16_W-1:0]       conf;
      logic [FORCE_WIDTH-1:0] pf;
      logic [FORCE_WIDTH-1:0] wf;
      logic [FORCE_WIDTH-1:0] p_echo;
      logic [FORCE_WIDTH-1:0] w_echo;
   } entry_type;

   function automatic logic [Q16_W-1:0] clamp_q16(input logic [Q16_W-1:0] v);
      return (v > Q16_ONE) ? Q16_ONE : v;
   endfunction

   function automatic logic [FORCE_WIDTH-1:0] sat_force(input logic [FORCE_WIDTH:0] v);
      logic [FORCE_WIDTH-1:0] res;
      if (v[FORCE_WIDTH] != v[FORCE_WIDTH-1]) begin
         res = {v[FORCE_WIDTH], {(FORCE_WIDTH-1){~v[FORCE_WIDTH]}}};
      end else begin
         res = v[FORCE_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

### sv/dsff_front.sv
// Front end: takes items, keeps the bias, checks freshness and picks the source.
module dsff_front
   import dsff_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic signed [FORCE_WIDTH-1:0] req_pressure_force,
   input  logic                          req_pressure_ok,
   input  logic signed [AGE_WIDTH-1:0]   req_pressure_age,
   input  logic signed [FORCE_WIDTH-1:0] req_wrench_force,
   input  logic                          req_wrench_ok,
   input  logic signed [AGE_WIDTH-1:0]   req_wrench_age,
   input  logic signed [1:0]             req_contact_sign,
   input  logic                          q_full,
   output logic                          q_push,
   output entry_type                     q_entry
);

   logic [FORCE_WIDTH-1:0] bias_ff, bias_in;
   logic [STALE_W-1:0]     stale_eff;
   logic                   p_fresh, w_fresh, az_hit, accept;
   logic [FORCE_WIDTH-1:0] bias_use;
   logic [FORCE_WIDTH:0]   p_diff, w_ext, w_signed;
   src_type                src;
   logic [Q16_W-1:0]       conf;

   function automatic logic is_fresh(input logic ok, input logic [AGE_WIDTH-1:0] age,
                                     input logic [STALE_W-1:0] lim);
      logic signed [AGE_CMP_W-1:0] age_x, lim_x;
      age_x = AGE_CMP_W'($signed(age));
      lim_x = AGE_CMP_W'(lim);
      return ok && !age[AGE_WIDTH-1] && (age_x <= lim_x);
   endfunction

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign stale_eff = (cfg.stale_timeout == '0) ? STALE_W'(1) : cfg.stale_timeout;

   always_comb begin
      p_fresh  = is_fresh(req_pressure_ok, req_pressure_age, stale_eff);
      w_fresh  = is_fresh(req_wrench_ok, req_wrench_age, stale_eff);
      az_hit   = cfg.auto_zero_enable && p_fresh &&
                 (req_pressure_force > AZ_LO) && (req_pressure_force < AZ_HI);
      bias_use = az_hit ? req_pressure_force : bias_ff;
      p_diff   = {req_pressure_force[FORCE_WIDTH-1], req_pressure_force}
               - {bias_use[FORCE_WIDTH-1], bias_use};
      w_ext    = {req_wrench_force[FORCE_WIDTH-1], req_wrench_force};
      w_signed = req_contact_sign[1] ? -w_ext : w_ext;

      src = SRC_INVALID;
      unique case (cfg.src_pref)
         PREF_PRESSURE: begin
            if (p_fresh) src = SRC_PRESSURE;
            else if (w_fresh) src = SRC_WRENCH;
         end
         PREF_WRENCH: begin
            if (w_fresh) src = SRC_WRENCH;
            else if (p_fresh) src = SRC_PRESSURE;
         end
         default: begin
            if (p_fresh && w_fresh) src = SRC_FUSED;
            else if (p_fresh) src = SRC_PRESSURE;
            else if (w_fresh) src = SRC_WRENCH;
         end
      endcase

      unique case (src)
         SRC_PRESSURE: conf = CONF_P;
         SRC_WRENCH:   conf = CONF_W;
         SRC_FUSED:    conf = CONF_F;
         default:      conf = '0;
      endcase

      // below minimum: report the source's confidence but no estimate
      if (conf < clamp_q16(cfg.conf_floor)) begin
         src = SRC_INVALID;
      end

      q_entry.src    = src;
      q_entry.conf   = conf;
      q_entry.pf     = sat_force(p_diff);
      q_entry.wf     = sat_force(w_signed);
      q_entry.p_echo = req_pressure_force;
      q_entry.w_echo = req_wrench_force;

      q_push = accept && (req_operation == OP_ESTIMATE);

      bias_in = bias_ff;
      if (accept) begin
         if (req_operation == OP_CLEAR) bias_in = '0;
         else if (az_hit) bias_in = req_pressure_force;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

endmodule

### sv/dsff_queue.sv
// Two-entry queue of classified items between front and back.
module dsff_queue
   import dsff_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   entry_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### sv/dsff_back.sv
// Back end: bypass or fusion with a shared multiplier and restoring divider, result register.
module dsff_back
   import dsff_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          q_not_empty,
   input  entry_type                     q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [FORCE_WIDTH-1:0] rsp_force_estimate,
   output logic signed [FORCE_WIDTH-1:0] rsp_pressure_echo,
   output logic signed [FORCE_WIDTH-1:0] rsp_wrench_echo,
   output logic [1:0]                    rsp_source_code,
   output logic [Q16_W-1:0]              rsp_confidence,
   output logic                          rsp_estimate_valid,
   output logic                          rsp_estimate_stale
);

   back_state_type state_ff, state_in;

   entry_type              work_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                   neg_ff;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [FORCE_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FORCE_WIDTH-1:0] est_ff, p_echo_ff, w_echo_ff;
   src_type                src_ff;
   logic [Q16_W-1:0]       conf_ff;

   logic [Q16_W-1:0]       pw_c, ww_c, pw, ww;
   logic [DEN_W-1:0]       den;
   logic signed [DEN_W-1:0]       mul_a;
   logic signed [FORCE_WIDTH-1:0] mul_b;
   logic signed [PROD_W-1:0]      prod;
   logic [ACC_W-1:0]       mag, dvd;
   logic [DEN_W:0]         rem_sh, trial;
   logic                   ge;

   logic                   out_free, take_direct, take_fused, emit_fused;
   entry_type              out_src_entry;
   logic [FORCE_WIDTH-1:0] direct_est, fused_est;

   // weights and divisor
   always_comb begin
      pw_c = clamp_q16(cfg.weight_p);
      ww_c = clamp_q16(cfg.weight_w);
      if (pw_c == '0 && ww_c == '0) begin
         pw = DEF_PW;
         ww = DEF_WW;
      end else begin
         pw = pw_c;
         ww = ww_c;
      end
      den = DEN_W'(pw) + DEN_W'(ww);
   end

   // shared multiplier and divider step
   always_comb begin
      mul_a  = (state_ff == BK_MUL_P) ? $signed(DEN_W'(pw)) : $signed(DEN_W'(ww));
      mul_b  = (state_ff == BK_MUL_P) ? $signed(work_ff.pf) : $signed(work_ff.wf);
      prod   = mul_a * mul_b;
      mag    = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      dvd    = mag + ACC_W'(den >> 1);
      rem_sh = {rem_ff, quo_ff[FORCE_WIDTH-1]};
      trial  = rem_sh - {1'b0, den};
      ge     = !trial[DEN_W];
      rem_in = ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_in = {quo_ff[FORCE_WIDTH-2:0], ge};
      fused_est = neg_ff ? -quo_ff : quo_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (q_not_empty && out_free && q_head.src == SRC_FUSED) state_in = BK_MUL_P;
         BK_MUL_P: state_in = BK_MUL_W;
         BK_MUL_W: state_in = BK_PREP;
         BK_PREP:  state_in = BK_DIV;
         BK_DIV:   if (cnt_ff == '0) state_in = BK_EMIT;
         BK_EMIT:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      q_pop       = (state_ff == BK_IDLE) && q_not_empty && out_free;
      take_fused  = q_pop && (q_head.src == SRC_FUSED);
      take_direct = q_pop && (q_head.src != SRC_FUSED);
      emit_fused  = (state_ff == BK_EMIT) && out_free;

      out_src_entry = emit_fused ? work_ff : q_head;
      unique case (q_head.src)
         SRC_PRESSURE: direct_est = q_head.pf;
         SRC_WRENCH:   direct_est = q_head.wf;
         default:      direct_est = '0;
      endcase

      if (take_direct || emit_fused) rsp_valid_in = 1'b1;
      else if (rsp_ready)            rsp_valid_in = 1'b0;
      else                           rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_fused) work_ff <= q_head;
      if (state_ff == BK_MUL_P) acc_ff <= ACC_W'(prod);
      if (state_ff == BK_MUL_W) acc_ff <= acc_ff + ACC_W'(prod);
      if (state_ff == BK_PREP) begin
         neg_ff <= acc_ff[ACC_W-1];
         rem_ff <= dvd[DEN_W+FORCE_WIDTH-1:FORCE_WIDTH];
         quo_ff <= dvd[FORCE_WIDTH-1:0];
         cnt_ff <= DIV_LAST;
      end
      if (state_ff == BK_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (take_direct || emit_fused) begin
         est_ff    <= emit_fused ? fused_est : direct_est;
         p_echo_ff <= out_src_entry.p_echo;
         w_echo_ff <= out_src_entry.w_echo;
         src_ff    <= out_src_entry.src;
         conf_ff   <= out_src_entry.conf;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_force_estimate = est_ff;
   assign rsp_pressure_echo  = p_echo_ff;
   assign rsp_wrench_echo    = w_echo_ff;
   assign rsp_source_code    = src_ff;
   assign rsp_confidence     = conf_ff;
   assign rsp_estimate_valid = (src_ff != SRC_INVALID);
   assign rsp_estimate_stale = (src_ff == SRC_INVALID);

endmodule

### sv/dual_sensor_force_fusion.sv
// Top level of the dual sensor force fusion block: registers, front end, queue, back end.
//
// A single-source or invalid estimate passes the front end in the cycle it is
// taken, is written into the two-entry queue, and is loaded into the result
// register at the edge where the back end pulls it from the queue, once the back
// end is free. A fused estimate occupies the back end after it is pulled: the
// shared multiplier forms the weighted sum from the pressure and the wrench
// product, a preparation step takes the magnitude and adds the rounding offset,
// and the restoring divider gives one quotient bit per cycle; the result is then
// loaded into the result register once the output is free.
// Clear-bias items update the bias register and produce no result.
module dual_sensor_force_fusion
   import dsff_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic signed [FORCE_WIDTH-1:0] req_pressure_force,
   input  logic                          req_pressure_ok,
   input  logic signed [AGE_WIDTH-1:0]   req_pressure_age,
   input  logic signed [FORCE_WIDTH-1:0] req_wrench_force,
   input  logic                          req_wrench_ok,
   input  logic signed [AGE_WIDTH-1:0]   req_wrench_age,
   input  logic signed [1:0]             req_contact_sign,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [FORCE_WIDTH-1:0] rsp_force_estimate,
   output logic signed [FORCE_WIDTH-1:0] rsp_pressure_echo,
   output logic signed [FORCE_WIDTH-1:0] rsp_wrench_echo,
   output logic [1:0]                    rsp_source_code,
   output logic [Q16_W-1:0]              rsp_confidence,
   output logic                          rsp_estimate_valid,
   output logic                          rsp_estimate_stale,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_push, q_pop, q_full, q_not_empty;
   entry_type q_entry, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PRESSURE_WEIGHT: cfg_in.weight_p         = csr_data[Q16_W-1:0];
            CSR_WRENCH_WEIGHT:   cfg_in.weight_w         = csr_data[Q16_W-1:0];
            CSR_STALE_TIMEOUT:   cfg_in.stale_timeout    = csr_data[STALE_W-1:0];
            CSR_MIN_CONFIDENCE:  cfg_in.conf_floor       = csr_data[Q16_W-1:0];
            CSR_AUTO_ZERO:       cfg_in.auto_zero_enable = csr_data[0];
            CSR_PREFERRED:       cfg_in.src_pref         = pref_type'(csr_data[PREF_W-1:0]);
            // hard limit and the unused index: nothing to store
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_p         <= '0;
         cfg_ff.weight_w         <= '0;
         cfg_ff.stale_timeout    <= STALE_W'(1);
         cfg_ff.conf_floor       <= '0;
         cfg_ff.auto_zero_enable <= 1'b0;
         cfg_ff.src_pref         <= PREF_FUSED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsff_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pressure_force (req_pressure_force),
      .req_pressure_ok    (req_pressure_ok),
      .req_pressure_age   (req_pressure_age),
      .req_wrench_force   (req_wrench_force),
      .req_wrench_ok      (req_wrench_ok),
      .req_wrench_age     (req_wrench_age),
      .req_contact_sign   (req_contact_sign),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (q_entry)
   );

   dsff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   dsff_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_force_estimate (rsp_force_estimate),
      .rsp_pressure_echo  (rsp_pressure_echo),
      .rsp_wrench_echo    (rsp_wrench_echo),
      .rsp_source_code    (rsp_source_code),
      .rsp_confidence     (rsp_confidence),
      .rsp_estimate_valid (rsp_estimate_valid),
      .rsp_estimate_stale (rsp_estimate_stale)
   );

endmodule

### bench/testbench.sv
// Self-checking testbench for the dual sensor force fusion block.
`timescale 1ns / 100ps

module testbench
   import dsff_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 200;

   typedef struct {
      op_type                        op;
      logic signed [FORCE_WIDTH-1:0] p_force;
      logic                          p_ok;
      logic signed [AGE_WIDTH-1:0]   p_age;
      logic signed [FORCE_WIDTH-1:0] w_force;
      logic                          w_ok;
      logic signed [AGE_WIDTH-1:0]   w_age;
      logic signed [1:0]             contact;
   } force_sample_type;

   typedef struct {
      logic signed [FORCE_WIDTH-1:0] estimate;
      logic signed [FORCE_WIDTH-1:0] p_echo;
      logic signed [FORCE_WIDTH-1:0] w_echo;
      src_type                       src;
      logic [Q16_W-1:0]              conf;
      logic                          valid;
      logic                          stale;
   } fusion_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_operation = 1'b0;
   logic signed [FORCE_WIDTH-1:0] req_pressure_force = '0;
   logic                          req_pressure_ok = 1'b0;
   logic signed [AGE_WIDTH-1:0]   req_pressure_age = '0;
   logic signed [FORCE_WIDTH-1:0] req_wrench_force = '0;
   logic                          req_wrench_ok = 1'b0;
   logic signed [AGE_WIDTH-1:0]   req_wrench_age = '0;
   logic signed [1:0]             req_contact_sign = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [FORCE_WIDTH-1:0] rsp_force_estimate;
   logic signed [FORCE_WIDTH-1:0] rsp_pressure_echo;
   logic signed [FORCE_WIDTH-1:0] rsp_wrench_echo;
   logic [1:0]                    rsp_source_code;
   logic [Q16_W-1:0]              rsp_confidence;
   logic                          rsp_estimate_valid;
   logic                          rsp_estimate_stale;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   // predictor state and register copies
   logic [Q16_W-1:0]              cfg_pw    = '0;
   logic [Q16_W-1:0]              cfg_ww    = '0;
   logic [STALE_W-1:0]            cfg_stale = 16'd1;
   logic [Q16_W-1:0]              cfg_minc  = '0;
   logic                          cfg_az    = 1'b0;
   pref_type                      cfg_pref  = PREF_FUSED;
   logic signed [FORCE_WIDTH-1:0] zero_bias = '0;

   fusion_result_type pending_results[$];
   fusion_result_type want;
   int  mismatch_count = 0;
   int  rsp_stall = 0;
   int  quiet_cycles = 0;
   bit  idle_on = 1'b1;
   logic rsp_hold = 1'b0;
   event start_hold_off;

   dual_sensor_force_fusion i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_pressure_force (req_pressure_force),
      .req_pressure_ok    (req_pressure_ok),
      .req_pressure_age   (req_pressure_age),
      .req_wrench_force   (req_wrench_force),
      .req_wrench_ok      (req_wrench_ok),
      .req_wrench_age     (req_wrench_age),
      .req_contact_sign   (req_contact_sign),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_force_estimate (rsp_force_estimate),
      .rsp_pressure_echo  (rsp_pressure_echo),
      .rsp_wrench_echo    (rsp_wrench_echo),
      .rsp_source_code    (rsp_source_code),
      .rsp_confidence     (rsp_confidence),
      .rsp_estimate_valid (rsp_estimate_valid),
      .rsp_estimate_stale (rsp_estimate_stale),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   function automatic longint clip_force(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (FORCE_WIDTH - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic bit is_fresh(input logic ok, input logic signed [AGE_WIDTH-1:0] age);
      longint window;
      window = (cfg_stale == 0) ? 1 : longint'(cfg_stale);
      return ok && (longint'(age) >= 0) && (longint'(age) <= window);
   endfunction

   function automatic bit predict_fusion(input force_sample_type s,
                                         output fusion_result_type r);
      bit      p_fresh, w_fresh;
      longint  p_val, w_val, est, num, den, mag, quo, pw, ww;
      src_type src;
      logic [Q16_W-1:0] conf, minc;
      if (s.op == OP_CLEAR) begin
         zero_bias = '0;
         return 1'b0;
      end
      p_fresh = is_fresh(s.p_ok, s.p_age);
      w_fresh = is_fresh(s.w_ok, s.w_age);
      if (cfg_az && p_fresh && longint'(s.p_force) > -64 && longint'(s.p_force) < 64) begin
         zero_bias = s.p_force;
      end
      p_val = clip_force(longint'(s.p_force) - longint'(zero_bias));
      w_val = clip_force(s.contact[1] ? -longint'(s.w_force) : longint'(s.w_force));
      src = SRC_INVALID;
      case (cfg_pref)
         PREF_PRESSURE: begin
            if (p_fresh) src = SRC_PRESSURE;
            else if (w_fresh) src = SRC_WRENCH;
         end
         PREF_WRENCH: begin
            if (w_fresh) src = SRC_WRENCH;
            else if (p_fresh) src = SRC_PRESSURE;
         end
         default: begin
            if (p_fresh && w_fresh) src = SRC_FUSED;
            else if (p_fresh) src = SRC_PRESSURE;
            else if (w_fresh) src = SRC_WRENCH;
         end
      endcase
      est = 0;
      conf = '0;
      case (src)
         SRC_PRESSURE: begin
            est = p_val;
            conf = 17'd45875;
         end
         SRC_WRENCH: begin
            est = w_val;
            conf = 17'd36045;
         end
         SRC_FUSED: begin
            pw = (cfg_pw > 17'd65536) ? 65536 : longint'(cfg_pw);
            ww = (cfg_ww > 17'd65536) ? 65536 : longint'(cfg_ww);
            if (pw == 0 && ww == 0) begin
               pw = 45875;
               ww = 19661;
            end
            num = pw * p_val + ww * w_val;
            den = pw + ww;
            mag = (num < 0) ? -num : num;
            quo = (mag + den / 2) / den;
            est = (num < 0) ? -quo : quo;
            conf = 17'd65536;
         end
         default: ;
      endcase
      minc = (cfg_minc > 17'd65536) ? 17'd65536 : cfg_minc;
      r.valid = (src != SRC_INVALID);
      if (conf < minc) begin
         r.valid = 1'b0;
         src = SRC_INVALID;
         est = 0;
      end
      r.estimate = FORCE_WIDTH'(est);
      r.p_echo   = s.p_force;
      r.w_echo   = s.w_force;
      r.src      = src;
      r.conf     = conf;
      r.stale    = ~r.valid;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint exp_val);
      $display("MISMATCH at %0t: %s got %0d, predicted %0d", $realtime, field, got, exp_val);
      mismatch_count++;
   endtask

   task automatic send_item(input force_sample_type s);
      fusion_result_type r;
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= s.op;
      req_pressure_force <= s.p_force;
      req_pressure_ok    <= s.p_ok;
      req_pressure_age   <= s.p_age;
      req_wrench_force   <= s.w_force;
      req_wrench_ok      <= s.w_ok;
      req_wrench_age     <= s.w_age;
      req_contact_sign   <= s.contact;
      do @(posedge clock); while (!req_ready);
      if (predict_fusion(s, r)) pending_results.push_back(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // clear items leave no result behind, so let the pipeline drain
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PRESSURE_WEIGHT: cfg_pw = val;
         CSR_WRENCH_WEIGHT:   cfg_ww = val;
         CSR_STALE_TIMEOUT:   cfg_stale = val[STALE_W-1:0];
         CSR_MIN_CONFIDENCE:  cfg_minc = val;
         CSR_AUTO_ZERO:       cfg_az = val[0];
         CSR_PREFERRED:       cfg_pref = pref_type'(val[PREF_W-1:0]);
         default: ;  // hard timeout never narrows the fresh window
      endcase
   endtask

   task automatic load_settings(input logic [Q16_W-1:0] pw, input logic [Q16_W-1:0] ww,
                                input logic [STALE_W-1:0] st, input logic [STALE_W-1:0] ht,
                                input logic [Q16_W-1:0] mc, input logic az,
                                input pref_type pref);
      wait_idle();
      write_reg(CSR_PRESSURE_WEIGHT, pw);
      write_reg(CSR_WRENCH_WEIGHT, ww);
      write_reg(CSR_STALE_TIMEOUT, 17'(st));
      write_reg(CSR_HARD_TIMEOUT, 17'(ht));
      write_reg(CSR_MIN_CONFIDENCE, mc);
      write_reg(CSR_AUTO_ZERO, 17'(az));
      write_reg(CSR_PREFERRED, 17'(pref));
      csr_valid <= 1'b0;
   endtask

   function automatic force_sample_type make_sample(
         input op_type op, input logic signed [FORCE_WIDTH-1:0] pf, input logic pok,
         input logic signed [AGE_WIDTH-1:0] page, input logic signed [FORCE_WIDTH-1:0] wf,
         input logic wok, input logic signed [AGE_WIDTH-1:0] wage,
         input logic signed [1:0] contact);
      force_sample_type s;
      s.op = op;
      s.p_force = pf;
      s.p_ok = pok;
      s.p_age = page;
      s.w_force = wf;
      s.w_ok = wok;
      s.w_age = wage;
      s.contact = contact;
      return s;
   endfunction

   function automatic logic signed [FORCE_WIDTH-1:0] random_force();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = int'($urandom_range(0, 200)) - 100;
         3:       v = 8388607;
         4:       v = -8388608;
         5:       v = int'($urandom_range(0, 200000)) - 100000;
         default: v = int'($urandom);
      endcase
      return FORCE_WIDTH'(v);
   endfunction

   function automatic logic signed [AGE_WIDTH-1:0] random_age();
      int st;
      st = (cfg_stale == 0) ? 1 : int'(cfg_stale);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return AGE_WIDTH'($urandom_range(0, st));
         5:             return AGE_WIDTH'(st);
         6:             return AGE_WIDTH'(st + 1);
         7:             return -AGE_WIDTH'($urandom_range(1, 65536));
         default:       return AGE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic force_sample_type random_sample();
      return make_sample(($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_ESTIMATE,
                         random_force(), $urandom_range(0, 6) != 0, random_age(),
                         random_force(), $urandom_range(0, 6) != 0, random_age(),
                         2'($urandom));
   endfunction

   function automatic logic [Q16_W-1:0] random_weight();
      case ($urandom_range(0, 4))
         0:       return 17'd0;
         1:       return 17'd65536;
         2:       return 17'($urandom);
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // reset register values: fused, default weights, one ms window
   task automatic test_reset_defaults();
      idle_on = 1'b1;
      send_item(make_sample(OP_ESTIMATE, 1000, 1, 0, 2000, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, 8388607, 1, 1, 8388607, 1, 1, 0));
      send_item(make_sample(OP_ESTIMATE, -8388608, 1, 0, -8388608, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, 5, 1, 0, -8388608, 1, 1, -1));
      send_item(make_sample(OP_ESTIMATE, -700, 1, 1, 300, 1, 2, 1));
      send_item(make_sample(OP_ESTIMATE, 400, 0, 0, 12345, 1, 0, -2));
      send_item(make_sample(OP_ESTIMATE, 400, 1, -1, 12345, 1, -1, 0));
      send_item(make_sample(OP_ESTIMATE, 1, 1, -65536, -1, 1, 65535, 1));
      send_item(make_sample(OP_CLEAR, -1, 1, 0, -1, 1, 0, -1));
   endtask

   task automatic test_source_priority();
      load_settings(17'd0, 17'd0, 16'd5, 16'd2, 17'd0, 1'b0, PREF_PRESSURE);
      send_item(make_sample(OP_ESTIMATE, -2222, 1, 5, 3333, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, -2222, 1, 6, 3333, 1, 4, -1));
      load_settings(17'd0, 17'd0, 16'd5, 16'd9, 17'd0, 1'b0, PREF_WRENCH);
      send_item(make_sample(OP_ESTIMATE, -2222, 1, 5, 3333, 1, 0, -1));
      send_item(make_sample(OP_ESTIMATE, -2222, 1, 3, 3333, 0, 0, 1));
      // code 3 falls back to fused; unit weights give exact halves
      load_settings(17'd1, 17'd1, 16'd5, 16'd5, 17'd0, 1'b0, PREF_ALT);
      send_item(make_sample(OP_ESTIMATE, 1, 1, 0, 0, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, -1, 1, 0, 0, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, 3, 1, 0, 0, 1, 0, 0));
   endtask

   task automatic test_auto_zero();
      load_settings(17'd0, 17'd0, 16'd10, 16'd0, 17'd0, 1'b1, PREF_PRESSURE);
      send_item(make_sample(OP_ESTIMATE, 50, 1, 3, 0, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, -8388608, 1, 3, 0, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, -63, 1, 10, 0, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, 8388607, 1, 5, 0, 1, 0, 1));
      send_item(make_sample(OP_ESTIMATE, 20, 0, 1, 777, 1, 2, 1));
      send_item(make_sample(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_sample(OP_ESTIMATE, 100, 1, 0, 0, 0, 0, 0));
   endtask

   task automatic test_conf_floor();
      load_settings(17'd30000, 17'd10000, 16'd3, 16'd3, 17'd45876, 1'b0, PREF_FUSED);
      send_item(make_sample(OP_ESTIMATE, 9000, 1, 0, -4000, 1, 3, 1));
      send_item(make_sample(OP_ESTIMATE, 9000, 1, 0, -4000, 1, 4, 1));
      send_item(make_sample(OP_ESTIMATE, 9000, 1, 4, -4000, 1, 3, 1));
      load_settings(17'd131071, 17'd0, 16'd3, 16'd3, 17'd131071, 1'b0, PREF_FUSED);
      send_item(make_sample(OP_ESTIMATE, 9000, 1, 0, -4000, 1, 3, -1));
      send_item(make_sample(OP_ESTIMATE, 9000, 0, 0, -4000, 0, 3, -1));
   endtask

   // receiver stops while the sender keeps offering items back to back
   task automatic test_backpressure();
      load_settings(17'd40000, 17'd25000, 16'd65535, 16'd100, 17'd0, 1'b0, PREF_FUSED);
      idle_on = 1'b0;
      -> start_hold_off;
      repeat (40) send_item(random_sample());
      idle_on = 1'b1;
   endtask

   task automatic test_random_phases();
      logic [STALE_W-1:0] st;
      logic [Q16_W-1:0]   mc;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: load_settings(17'd0, 17'd0, 16'd0, 16'd65535, 17'd0, 1'b1, PREF_FUSED);
            1: load_settings(17'd65536, 17'd0, 16'd65535, 16'd0, 17'd36045, 1'b0, PREF_ALT);
            2: load_settings(17'd131071, 17'd131071, 16'd1, 16'd1, 17'd65536, 1'b1,
                             PREF_FUSED);
            3: load_settings(17'd0, 17'd65536, 16'd20, 16'd7, 17'd36046, 1'b1, PREF_WRENCH);
            default: begin
               case ($urandom_range(0, 3))
                  0:       st = 16'($urandom);
                  1:       st = 16'd65535;
                  default: st = 16'($urandom_range(1, 50));
               endcase
               case ($urandom_range(0, 4))
                  0:       mc = 17'd0;
                  1:       mc = 17'd45875;
                  2:       mc = 17'd45876;
                  3:       mc = 17'($urandom);
                  default: mc = 17'($urandom_range(0, 36045));
               endcase
               load_settings(random_weight(), random_weight(), st, 16'($urandom), mc,
                             1'($urandom), pref_type'($urandom_range(0, 3)));
            end
         endcase
         for (int k = 0; k < 110; k++) begin
            if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(random_sample());
         end
      end
      idle_on = 1'b1;
   endtask

   initial forever begin
      @(start_hold_off);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unpredicted result, force_estimate", rsp_force_estimate, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_force_estimate !== want.estimate)
               report_mismatch("force_estimate", rsp_force_estimate, want.estimate);
            if (rsp_pressure_echo !== want.p_echo)
               report_mismatch("pressure_echo", rsp_pressure_echo, want.p_echo);
            if (rsp_wrench_echo !== want.w_echo)
               report_mismatch("wrench_echo", rsp_wrench_echo, want.w_echo);
            if (rsp_source_code !== want.src)
               report_mismatch("source_code", rsp_source_code, want.src);
            if (rsp_confidence !== want.conf)
               report_mismatch("confidence", rsp_confidence, want.conf);
            if (rsp_estimate_valid !== want.valid)
               report_mismatch("estimate_valid", rsp_estimate_valid, want.valid);
            if (rsp_estimate_stale !== want.stale)
               report_mismatch("estimate_stale", rsp_estimate_stale, want.stale);
         end
         rsp_stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_source_priority();
      test_auto_zero();
      test_conf_floor();
      test_backpressure();
      test_random_phases();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
sv/dsff_pkg.sv
sv/dsff_front.sv
sv/dsff_queue.sv
sv/dsff_back.sv
sv/dual_sensor_force_fusion.sv
bench/testbench.sv
